/* rtl/implicit_list_heap_allocator_top_defines.svh */
// Assertion macros shared by the heap allocator RTL.
`ifndef IMPLICIT_LIST_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define IMPLICIT_LIST_HEAP_ALLOCATOR_TOP_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define IHLA_ASSERT_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cond)) else $error(msg);

// The condition must hold in the cycle after the trigger.
`define IHLA_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

/* rtl/ihla_pkg.sv */
// Types and constants shared by the heap allocator modules.
package ihla_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int HEAP_BYTES_W = 14;
    localparam int REQ_W        = 16;
    localparam int OFF_W        = 13;
    localparam int NEED_W       = 14;

    // Granule geometry.
    localparam int GRANULE_BYTES   = 8;
    localparam int GRANULE_SHIFT   = 3;
    localparam int MIN_BLOCK_BYTES = 16;
    localparam int MIN_GRANULES    = 2;
    localparam int RESET_HEAP_BYTES = 8192;

    // Command codes.
    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO      = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_TOO_SMALL = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_CARVE,
        S_FREAD,
        S_FWRITE,
        S_DONE
    } t_state;

    // Flags from the shared walk unit.
    typedef struct packed {
        logic fits;
        logic past_end;
    } t_alu_flags;

endpackage

/* rtl/ihla_hdr_ram.sv */
// Header memory: one write port, one read port with registered read data.
module ihla_hdr_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Synchronous write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ihla_walk_alu.sv */
// Shared walk unit: next header position, fit compare and end block remainder.
module ihla_walk_alu #(
    parameter int AW            = 10,
    parameter int CW            = 15,
    parameter int HEAP_GRANULES = 1024
) (
    input  logic [AW-1:0]             i_pos,
    input  logic [AW-1:0]             i_size,
    input  logic [ihla_pkg::NEED_W-1:0] i_need,
    input  logic                      i_is_end,
    output logic [CW-1:0]             o_sum,
    output logic [AW-1:0]             o_rem,
    output ihla_pkg::t_alu_flags      o_flags
);

    import ihla_pkg::*;

    logic [CW-1:0] w_need_ext;
    logic [CW-1:0] w_size_ext;
    logic [CW-1:0] w_add_b;
    logic [CW-1:0] w_cmp_b;
    logic [CW-1:0] w_rem;

    // An end block must also hold the header of the new end block.
    assign w_need_ext = CW'(i_need);
    assign w_size_ext = CW'(i_size);
    assign w_add_b    = i_is_end ? w_need_ext : w_size_ext;
    assign w_cmp_b    = i_is_end ? (w_need_ext + CW'(1)) : w_need_ext;

    // One adder steps the walk or places the new end header.
    assign o_sum = CW'(i_pos) + w_add_b + CW'(1);

    // One subtractor gives both the fit test and the remaining size.
    assign w_rem            = w_size_ext - w_cmp_b;
    assign o_rem            = w_rem[AW-1:0];
    assign o_flags.fits     = (w_size_ext >= w_cmp_b);
    assign o_flags.past_end = (o_sum >= CW'(HEAP_GRANULES));

endmodule

/* rtl/implicit_list_heap_allocator_top.sv */
// Top level of the implicit free list first-fit heap allocator.
//
//  channel  direction  handshake                  payload
//  in       to block   i_in_valid / o_in_ready    i_cmd, i_request_bytes,
//                                                 i_release_offset, i_release_is_null
//  out      from block o_out_valid / i_out_ready  o_status, o_payload_offset
//  cfg      to block   APB psel/penable/pwrite    heap_bytes at address 0
//
// One transaction is in flight at a time. Init, zero-size requests, unknown commands
// and ignored frees go straight to the done state that loads the result register, as
// does a free of header 0; any other free passes a memory read state, then a write
// state. Allocate does a registered memory read, then the shared walk unit, for each
// header visited on the walk, plus a carve state when the carved end block is not header 0.
// Header 0 lives in flip-flops and is set by reset; the header memory needs no clearing.
// A finished result waits in the output register; a new transaction is accepted while
// it waits, and stalls only in its done state until the register is free.
`include "implicit_list_heap_allocator_top_defines.svh"

module implicit_list_heap_allocator_top #(
    parameter int HEAP_GRANULES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Command channel.
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_cmd,
    input  logic [ihla_pkg::REQ_W-1:0]        i_request_bytes,
    input  logic [ihla_pkg::OFF_W-1:0]        i_release_offset,
    input  logic                              i_release_is_null,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic [ihla_pkg::OFF_W-1:0]        o_payload_offset,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [1:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    import ihla_pkg::*;

    localparam int AW = $clog2(HEAP_GRANULES);
    localparam int CW = ((AW + 1 > NEED_W) ? AW + 1 : NEED_W) + 1;
    localparam int DW = AW + 2;
    localparam int RST_G = (RESET_HEAP_BYTES / GRANULE_BYTES > HEAP_GRANULES) ?
                           HEAP_GRANULES : RESET_HEAP_BYTES / GRANULE_BYTES;
    localparam logic [AW-1:0] RST_SIZE = AW'(RST_G - 1);

    t_state r_state, n_state;

    logic [HEAP_BYTES_W-1:0] r_heap_bytes;
    logic [AW-1:0]           r_hdr0_size, n_hdr0_size;
    logic                    r_hdr0_free, n_hdr0_free;
    logic                    r_hdr0_end,  n_hdr0_end;
    logic [AW-1:0]           r_pos, n_pos;
    logic [NEED_W-1:0]       r_need, n_need;
    logic [1:0]              r_res_status, n_res_status;
    logic [OFF_W-1:0]        r_res_off, n_res_off;
    logic                    r_out_valid, n_out_valid;
    logic [1:0]              r_out_status, n_out_status;
    logic [OFF_W-1:0]        r_out_off, n_out_off;

    logic                    w_in_acc;
    logic                    w_cfg_wr;
    logic                    w_done_ld;
    logic [REQ_W:0]          w_req_round;
    logic [NEED_W-1:0]       w_need_raw;
    logic [NEED_W-1:0]       w_need;
    logic                    w_req_zero;
    logic                    w_too_small;
    logic [CW-1:0]           w_init_raw;
    logic [CW-1:0]           w_init_g;
    logic [AW-1:0]           w_init_size;
    logic                    w_rel_ok;
    logic [CW-1:0]           w_rel_idx;
    logic                    w_rel_in;
    logic                    w_rel_zero;
    logic                    w_at_zero;
    logic [DW-1:0]           w_rdata;
    logic [AW-1:0]           w_h_size;
    logic                    w_h_free;
    logic                    w_h_end;
    logic [CW-1:0]           w_sum;
    logic [AW-1:0]           w_rem;
    t_alu_flags              w_flags;
    logic                    w_end_fail;
    logic                    w_take_free;
    logic [CW-1:0]           w_pos_inc;
    logic [OFF_W-1:0]        w_hit_off;
    logic                    w_mem_we;
    logic [AW-1:0]           w_mem_waddr;
    logic [DW-1:0]           w_mem_wdata;

    // Handshakes.
    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_done_ld = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_bytes <= HEAP_BYTES_W'(RESET_HEAP_BYTES);
        end else if (w_cfg_wr && (paddr == 2'd0)) begin
            r_heap_bytes <= pwdata[HEAP_BYTES_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? 32'(r_heap_bytes) : 32'd0;

    // Request decode: round up to granules with a two-granule minimum.
    assign w_req_round = {1'b0, i_request_bytes} + (REQ_W + 1)'(GRANULE_BYTES - 1);
    assign w_need_raw  = w_req_round[REQ_W:GRANULE_SHIFT];
    assign w_need      = (w_need_raw < NEED_W'(MIN_GRANULES)) ?
                         NEED_W'(MIN_GRANULES) : w_need_raw;
    assign w_req_zero  = (i_request_bytes == '0);

    // Init decode: granule count saturates at the heap depth.
    assign w_too_small = (r_heap_bytes < HEAP_BYTES_W'(MIN_BLOCK_BYTES));
    assign w_init_raw  = CW'(r_heap_bytes[HEAP_BYTES_W-1:GRANULE_SHIFT]);
    assign w_init_g    = (w_init_raw > CW'(HEAP_GRANULES)) ? CW'(HEAP_GRANULES) : w_init_raw;
    assign w_init_size = AW'(w_init_g - CW'(1));

    // Free decode: null, unaligned and out-of-range offsets are ignored.
    assign w_rel_ok   = !i_release_is_null &&
                        (i_release_offset >= OFF_W'(GRANULE_BYTES)) &&
                        (i_release_offset[GRANULE_SHIFT-1:0] == '0);
    assign w_rel_idx  = CW'(i_release_offset[OFF_W-1:GRANULE_SHIFT]) - CW'(1);
    assign w_rel_in   = (w_rel_idx < CW'(HEAP_GRANULES));
    assign w_rel_zero = (w_rel_idx == '0);

    // Header memory; header 0 is held in flip-flops instead.
    ihla_hdr_ram #(
        .DEPTH (HEAP_GRANULES),
        .AW    (AW),
        .DW    (DW)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (r_pos),
        .o_rdata (w_rdata)
    );

    // Current header on the walk.
    assign w_at_zero = (r_pos == '0);
    assign w_h_size  = w_at_zero ? r_hdr0_size : w_rdata[DW-1:2];
    assign w_h_free  = w_at_zero ? r_hdr0_free : w_rdata[1];
    assign w_h_end   = w_at_zero ? r_hdr0_end  : w_rdata[0];

    ihla_walk_alu #(
        .AW            (AW),
        .CW            (CW),
        .HEAP_GRANULES (HEAP_GRANULES)
    ) u_walk_alu (
        .i_pos    (r_pos),
        .i_size   (w_h_size),
        .i_need   (r_need),
        .i_is_end (w_h_end),
        .o_sum    (w_sum),
        .o_rem    (w_rem),
        .o_flags  (w_flags)
    );

    // Walk decisions for the current header.
    assign w_end_fail  = !w_h_free || !w_flags.fits || w_flags.past_end;
    assign w_take_free = !w_h_end && w_h_free && w_flags.fits;
    assign w_pos_inc   = CW'(r_pos) + CW'(1);
    assign w_hit_off   = {w_pos_inc[OFF_W-GRANULE_SHIFT-1:0], {GRANULE_SHIFT{1'b0}}};

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_cmd)
                        CMD_ALLOC: n_state = w_req_zero ? S_DONE : S_READ;
                        CMD_FREE: begin
                            n_state = (w_rel_ok && w_rel_in && !w_rel_zero) ? S_FREAD : S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_READ: n_state = S_CHECK;
            S_CHECK: begin
                if (w_h_end) begin
                    n_state = (w_end_fail || w_at_zero) ? S_DONE : S_CARVE;
                end else if (w_take_free || w_flags.past_end) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_CARVE:  n_state = S_DONE;
            S_FREAD:  n_state = S_FWRITE;
            S_FWRITE: n_state = S_DONE;
            S_DONE:   n_state = w_done_ld ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Output logic: ready and header memory writes.
    always_comb begin
        o_in_ready  = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_pos;
        w_mem_wdata = '0;
        case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_CHECK: begin
                if (w_h_end && !w_end_fail) begin
                    // New end block right after the carved payload.
                    w_mem_we    = 1'b1;
                    w_mem_waddr = w_sum[AW-1:0];
                    w_mem_wdata = {w_rem, 1'b1, 1'b1};
                end else if (!w_h_end && w_take_free && !w_at_zero) begin
                    w_mem_we    = 1'b1;
                    w_mem_wdata = {w_h_size, 1'b0, 1'b0};
                end
            end
            S_CARVE: begin
                w_mem_we    = 1'b1;
                w_mem_wdata = {AW'(r_need), 1'b0, 1'b0};
            end
            S_FWRITE: begin
                w_mem_we    = 1'b1;
                w_mem_wdata = {w_rdata[DW-1:2], 1'b1, w_rdata[0]};
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_hdr0_size  = r_hdr0_size;
        n_hdr0_free  = r_hdr0_free;
        n_hdr0_end   = r_hdr0_end;
        n_pos        = r_pos;
        n_need       = r_need;
        n_res_status = r_res_status;
        n_res_off    = r_res_off;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_off    = r_out_off;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_res_status = ST_OK;
                    n_res_off    = '0;
                    n_pos        = '0;
                    n_need       = w_need;
                    case (i_cmd)
                        CMD_INIT: begin
                            if (w_too_small) begin
                                n_res_status = ST_TOO_SMALL;
                            end else begin
                                n_hdr0_size = w_init_size;
                                n_hdr0_free = 1'b1;
                                n_hdr0_end  = 1'b1;
                            end
                        end
                        CMD_ALLOC: begin
                            if (w_req_zero) begin
                                n_res_status = ST_ZERO;
                            end
                        end
                        CMD_FREE: begin
                            if (w_rel_ok && w_rel_in) begin
                                if (w_rel_zero) begin
                                    n_hdr0_free = 1'b1;
                                end else begin
                                    n_pos = w_rel_idx[AW-1:0];
                                end
                            end
                        end
                        default: n_res_status = ST_OK;
                    endcase
                end
            end
            S_CHECK: begin
                if (w_h_end) begin
                    if (w_end_fail) begin
                        n_res_status = ST_EXHAUSTED;
                    end else begin
                        n_res_off = w_hit_off;
                        if (w_at_zero) begin
                            n_hdr0_size = AW'(r_need);
                            n_hdr0_free = 1'b0;
                            n_hdr0_end  = 1'b0;
                        end
                    end
                end else if (w_take_free) begin
                    n_res_off = w_hit_off;
                    if (w_at_zero) begin
                        n_hdr0_free = 1'b0;
                    end
                end else if (w_flags.past_end) begin
                    n_res_status = ST_EXHAUSTED;
                end else begin
                    n_pos = w_sum[AW-1:0];
                end
            end
            S_DONE: begin
                if (w_done_ld) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_off    = r_res_off;
                end
            end
            default: n_pos = r_pos;
        endcase
    end

    // Control and header 0 registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_hdr0_size <= RST_SIZE;
            r_hdr0_free <= 1'b1;
            r_hdr0_end  <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_hdr0_size <= n_hdr0_size;
            r_hdr0_free <= n_hdr0_free;
            r_hdr0_end  <= n_hdr0_end;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_need       <= n_need;
        r_res_status <= n_res_status;
        r_res_off    <= n_res_off;
        r_out_status <= n_out_status;
        r_out_off    <= n_out_off;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_payload_offset = r_out_off;

    // Checks on the sequencer and header 0.
    `IHLA_ASSERT_NEXT(a_alloc_starts_at_zero, w_in_acc && (i_cmd == CMD_ALLOC) && !w_req_zero, (r_state == S_READ) && (r_pos == '0), "allocate walk did not start at header 0")
    `IHLA_ASSERT_NOW(a_hdr0_end_is_free, r_hdr0_end, r_hdr0_free, "end block at header 0 is not free")
    `IHLA_ASSERT_NOW(a_fail_has_no_offset, (r_state == S_DONE) && (r_res_status != ST_OK), r_res_off == '0, "failed transaction carries an offset")
    `IHLA_ASSERT_NOW(a_write_states_only, w_mem_we, (r_state == S_CHECK) || (r_state == S_CARVE) || (r_state == S_FWRITE), "header write outside a write state")
    `IHLA_ASSERT_NEXT(a_done_loads_output, w_done_ld, o_out_valid && (r_state == S_IDLE), "finished result not loaded into the output register")

endmodule
